// ===== sv/tccs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and the color palette for the text console cursor/scroll unit.
package tccs_pkg;

  localparam int DEF_COLS = 50;
  localparam int DEF_ROWS = 37;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] COLOR_RESET  = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [5:0] target_column;
    logic [5:0] target_row;
  } in_req_t;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        cell_valid;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
    logic        scrolled;
    logic [5:0]  cursor_column;
    logic [5:0]  cursor_row;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_read;
    logic sweep_wr;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_clear;
    logic scroll_req;
    logic read_ok;
    logic sweep_last;
  } dp_stat_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ===== sv/tccs_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences requests, reads and fill sweeps.
module tccs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tccs_pkg::dp_stat_t  stat,
  output tccs_pkg::ctrl_cmd_t cmd
);
  import tccs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        // Power-up pass that fills every cell with a blank.
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_clear || stat.scroll_req) begin
          state_nxt = ST_SWEEP;
        end else if (stat.read_ok) begin
          state_nxt = ST_READ;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        cmd.emit      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tccs_dp.sv =====
`timescale 1ns / 1ps
// Datapath: cursor, row rotation offset, cell memory, fill sweep and result register.
module tccs_dp #(
  parameter int COLS = tccs_pkg::DEF_COLS,
  parameter int ROWS = tccs_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tccs_pkg::in_req_t   in_req,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  tccs_pkg::ctrl_cmd_t cmd,
  output tccs_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output tccs_pkg::out_res_t  out_res
);
  import tccs_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam logic [5:0]        LAST_COL = 6'(COLS - 1);
  localparam logic [5:0]        LAST_ROW = 6'(ROWS - 1);
  localparam logic [6:0]        ROWS_7   = 7'(ROWS);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(NCELLS - 1);

  logic [15:0]       mem [NCELLS];
  logic [15:0]       rd_data_r;

  in_req_t           req_r;
  logic [7:0]        text_color_r;
  logic [5:0]        cur_col_r, cur_row_r;
  logic [5:0]        top_r;
  logic [ADDR_W-1:0] sweep_addr_r, sweep_end_r;
  logic [7:0]        fill_attr_r;
  logic              sweep_scroll_r;
  out_res_t          res_r;
  logic              out_valid_r;

  logic [5:0]        col_nxt, row_nxt;
  logic              is_put, is_nl, is_bs, stored, bs_ok, wrap, adv_row, scroll_req;
  logic              cell_wr, read_ok;
  logic [5:0]        acc_col, acc_row;
  logic [6:0]        row_sum;
  logic [5:0]        phys_row;
  logic [ADDR_W-1:0] cell_addr, top_base;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [7:0]        wr_char;
  out_res_t          res_exec;

  always_comb begin
    is_put     = (req_r.cmd == CMD_PUT);
    is_nl      = (req_r.char_code == CH_NEWLINE);
    is_bs      = (req_r.char_code == CH_BACKSPACE);
    stored     = is_put && !is_nl && !is_bs;
    bs_ok      = (cur_col_r != 6'd0);
    wrap       = stored && (cur_col_r == LAST_COL);
    adv_row    = is_put && (is_nl || wrap);
    scroll_req = adv_row && (cur_row_r == LAST_ROW);
    cell_wr    = stored || (is_put && is_bs && bs_ok);
    read_ok    = (req_r.cmd == CMD_READ) && (req_r.target_column <= LAST_COL) &&
                 (req_r.target_row <= LAST_ROW);
  end

  // Cursor after the request.
  always_comb begin
    col_nxt = cur_col_r;
    row_nxt = cur_row_r;
    unique case (req_r.cmd)
      CMD_PUT: begin
        if (is_nl || wrap) begin
          col_nxt = 6'd0;
        end else if (is_bs) begin
          col_nxt = bs_ok ? cur_col_r - 6'd1 : cur_col_r;
        end else begin
          col_nxt = cur_col_r + 6'd1;
        end
        if (adv_row) begin
          row_nxt = scroll_req ? LAST_ROW : cur_row_r + 6'd1;
        end
      end
      CMD_SET: begin
        if (req_r.target_column <= LAST_COL) col_nxt = req_r.target_column;
        if (req_r.target_row <= LAST_ROW)    row_nxt = req_r.target_row;
      end
      CMD_CLEAR: begin
        col_nxt = 6'd0;
        row_nxt = 6'd0;
      end
      CMD_READ: begin
        col_nxt = cur_col_r;
        row_nxt = cur_row_r;
      end
    endcase
  end

  // Logical rows map to physical rows through a rotating top offset, so a
  // scroll only needs to blank one physical row.
  always_comb begin
    if (req_r.cmd == CMD_READ) begin
      acc_col = req_r.target_column;
      acc_row = req_r.target_row;
    end else begin
      acc_col = is_bs ? cur_col_r - 6'd1 : cur_col_r;
      acc_row = cur_row_r;
    end
    row_sum   = {1'b0, acc_row} + {1'b0, top_r};
    phys_row  = (row_sum >= ROWS_7) ? 6'(row_sum - ROWS_7) : row_sum[5:0];
    cell_addr = ADDR_W'(phys_row) * COLS_A + ADDR_W'(acc_col);
    top_base  = ADDR_W'(top_r) * COLS_A;
  end

  always_comb begin
    wr_char = stored ? req_r.char_code : CH_SPACE;
    if (cmd.sweep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_r;
      mem_wdata = {CH_SPACE, fill_attr_r};
    end else begin
      mem_we    = cmd.exec && cell_wr;
      mem_waddr = cell_addr;
      mem_wdata = {wr_char, text_color_r};
    end
  end

  always_comb begin
    res_exec               = '0;
    res_exec.echo_valid    = is_put;
    res_exec.echo_byte     = is_put ? req_r.char_code : 8'd0;
    res_exec.scrolled      = scroll_req;
    res_exec.cursor_column = col_nxt;
    res_exec.cursor_row    = row_nxt;
    if (is_put && cell_wr) begin
      res_exec.cell_valid  = 1'b1;
      res_exec.cell_column = acc_col;
      res_exec.cell_row    = acc_row;
      res_exec.cell_char   = wr_char;
      res_exec.cell_attr   = text_color_r;
      res_exec.fg_rgb      = palette_rgb(text_color_r[3:0]);
      res_exec.bg_rgb      = palette_rgb(text_color_r[7:4]);
    end else if (read_ok) begin
      // Cell contents are loaded from the registered memory read port in the next cycle.
      res_exec.cell_valid  = 1'b1;
      res_exec.cell_column = acc_col;
      res_exec.cell_row    = acc_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.exec && read_ok) begin
      rd_data_r <= mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.exec) begin
      res_r <= res_exec;
    end else if (cmd.load_read) begin
      res_r.cell_char <= rd_data_r[15:8];
      res_r.cell_attr <= rd_data_r[7:0];
      res_r.fg_rgb    <= palette_rgb(rd_data_r[3:0]);
      res_r.bg_rgb    <= palette_rgb(rd_data_r[7:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= COLOR_RESET;
      cur_col_r      <= 6'd0;
      cur_row_r      <= 6'd0;
      top_r          <= 6'd0;
      sweep_addr_r   <= '0;
      sweep_end_r    <= LAST_A;
      fill_attr_r    <= COLOR_RESET;
      sweep_scroll_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        cur_col_r <= col_nxt;
        cur_row_r <= row_nxt;
        if (req_r.cmd == CMD_CLEAR) begin
          top_r          <= 6'd0;
          sweep_addr_r   <= '0;
          sweep_end_r    <= LAST_A;
          fill_attr_r    <= text_color_r;
          sweep_scroll_r <= 1'b0;
        end else if (scroll_req) begin
          // The old top row becomes the new bottom row.
          sweep_addr_r   <= top_base;
          sweep_end_r    <= top_base + COLS_A - ADDR_W'(1);
          fill_attr_r    <= text_color_r;
          sweep_scroll_r <= 1'b1;
        end
      end
      if (cmd.sweep_wr) begin
        sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
        if (stat.sweep_last && sweep_scroll_r) begin
          top_r <= (top_r == LAST_ROW) ? 6'd0 : top_r + 6'd1;
        end
      end
    end
  end

  always_comb begin
    stat.is_clear   = (req_r.cmd == CMD_CLEAR);
    stat.scroll_req = scroll_req;
    stat.read_ok    = read_ok;
    stat.sweep_last = (sweep_addr_r == sweep_end_r);
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== sv/text_console_cursor_scroll_unit.sv =====
`timescale 1ns / 1ps
// Top level of the text console cell store with cursor and scrolling.
//
//   Channel   Ports                        Handshake
//   request   start, busy, in_req          taken when start is high and busy is low
//   result    out_valid, out_res           one-cycle strobe, one result per request
//   config    cfg_wr_en, cfg_wr_data       text_color written on any cycle with cfg_wr_en
//
// Put, set cursor and an out-of-range read pass through the exec state alone; a read also
// passes through the read state because of the registered cell memory read port. A put that
// scrolls blanks one row and a clear blanks every cell, both through the single memory write
// port blanking one cell per cycle. After reset the block is busy while every cell is
// filled with a blank. The result strobe cannot be stalled.
module text_console_cursor_scroll_unit #(
  parameter int COLS = tccs_pkg::DEF_COLS,
  parameter int ROWS = tccs_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tccs_pkg::in_req_t  in_req,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  output logic               out_valid,
  output tccs_pkg::out_res_t out_res
);
  import tccs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tccs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tccs_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_res     (out_res)
  );

endmodule

// ===== dv/text_console_cursor_scroll_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text console cell store with cursor and scrolling.
module text_console_cursor_scroll_unit_test;
  import tccs_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * COLS;
  localparam int PHASE_ITEMS = 230;
  localparam int RANDOM_PHASES = 8;
  localparam int CLEAR_BUDGET = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic out_valid;
  out_res_t out_res;

  text_console_cursor_scroll_unit #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted screen contents, cursor and current text color.
  logic [7:0] grid_char [CELLS];
  logic [7:0] grid_attr [CELLS];
  int cur_x;
  int cur_y;
  logic [7:0] color_reg;
  logic [23:0] vga_rgb [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  in_req_t cmd_backlog [$];
  out_res_t due_results [$];
  int queued_total = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int idle_on = 0;
  int clears_left = CLEAR_BUDGET;
  int scroll_count = 0;
  int clear_count = 0;
  int read_count = 0;
  int color_count = 0;
  logic req_taken = 1'b0;
  int gap_left = 0;

  function automatic void blank_all();
    for (int i = 0; i < CELLS; i++) begin
      grid_char[i] = CH_SPACE;
      grid_attr[i] = color_reg;
    end
  endfunction

  // Moves the cursor down one row, scrolling when it runs off the bottom.
  function automatic logic advance_row();
    cur_y++;
    if (cur_y < ROWS) return 1'b0;
    for (int i = 0; i < CELLS - COLS; i++) begin
      grid_char[i] = grid_char[i + COLS];
      grid_attr[i] = grid_attr[i + COLS];
    end
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      grid_char[i] = CH_SPACE;
      grid_attr[i] = color_reg;
    end
    cur_y = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic void report_cell(inout out_res_t o, input int x, input int y);
    logic [7:0] a;
    a = grid_attr[y * COLS + x];
    o.cell_valid = 1'b1;
    o.cell_column = 6'(x);
    o.cell_row = 6'(y);
    o.cell_char = grid_char[y * COLS + x];
    o.cell_attr = a;
    o.fg_rgb = vga_rgb[a[3:0]];
    o.bg_rgb = vga_rgb[a[7:4]];
  endfunction

  function automatic out_res_t console_step(input in_req_t r);
    out_res_t o;
    o = '0;
    case (r.cmd)
      CMD_PUT: begin
        o.echo_valid = 1'b1;
        o.echo_byte = r.char_code;
        if (r.char_code == CH_NEWLINE) begin
          cur_x = 0;
          o.scrolled = advance_row();
        end else if (r.char_code == CH_BACKSPACE) begin
          if (cur_x > 0) begin
            cur_x--;
            grid_char[cur_y * COLS + cur_x] = CH_SPACE;
            grid_attr[cur_y * COLS + cur_x] = color_reg;
            report_cell(o, cur_x, cur_y);
          end
        end else begin
          // The cell is reported where it landed, before any wrap or scroll.
          grid_char[cur_y * COLS + cur_x] = r.char_code;
          grid_attr[cur_y * COLS + cur_x] = color_reg;
          report_cell(o, cur_x, cur_y);
          cur_x++;
          if (cur_x >= COLS) begin
            cur_x = 0;
            o.scrolled = advance_row();
          end
        end
      end
      CMD_SET: begin
        if (r.target_column < COLS) cur_x = r.target_column;
        if (r.target_row < ROWS) cur_y = r.target_row;
      end
      CMD_CLEAR: begin
        blank_all();
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (r.target_column < COLS && r.target_row < ROWS)
          report_cell(o, r.target_column, r.target_row);
      end
    endcase
    o.cursor_column = 6'(cur_x);
    o.cursor_row = 6'(cur_y);
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    if (idle_on == 0) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic post(input cmd_t c, input logic [7:0] ch, input logic [5:0] x,
                      input logic [5:0] y);
    in_req_t r;
    r.cmd = c;
    r.char_code = ch;
    r.target_column = x;
    r.target_row = y;
    cmd_backlog.push_back(r);
    queued_total++;
  endtask

  // Mostly puts, with cursor moves that favor the bottom row so scrolls come often.
  task automatic post_random();
    int pick;
    logic [7:0] ch;
    logic [5:0] x;
    logic [5:0] y;
    pick = $urandom_range(0, 999);
    ch = 8'($urandom);
    x = 6'($urandom);
    y = 6'($urandom);
    if (pick < 20 && clears_left > 0) begin
      clears_left--;
      post(CMD_CLEAR, ch, x, y);
    end else if (pick < 600) begin
      case ($urandom_range(0, 9))
        0, 1: ch = CH_NEWLINE;
        2, 3: ch = CH_BACKSPACE;
        default: ;
      endcase
      post(CMD_PUT, ch, x, y);
    end else if (pick < 750) begin
      if ($urandom_range(0, 9) < 7) begin
        x = 6'($urandom_range(0, COLS - 1));
        y = ($urandom_range(0, 2) == 0) ? 6'(ROWS - 1) : 6'($urandom_range(0, ROWS - 1));
      end
      post(CMD_SET, ch, x, y);
    end else begin
      if ($urandom_range(0, 9) < 8) begin
        x = 6'($urandom_range(0, COLS - 1));
        y = 6'($urandom_range(0, ROWS - 1));
      end
      post(CMD_READ, ch, x, y);
    end
  endtask

  // Waits until every queued request has produced its result and the block is idle.
  task automatic settle();
    do @(negedge clk); while (results_seen != queued_total || busy);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        in_req <= cmd_backlog.pop_front();
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_res_t want;
    string diff;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request outstanding: %h", out_res);
        end else begin
          want = due_results.pop_front();
          diff = "";
          if (out_res.echo_valid !== want.echo_valid) diff = {diff, " echo_valid"};
          if (out_res.echo_byte !== want.echo_byte) diff = {diff, " echo_byte"};
          if (out_res.cell_valid !== want.cell_valid) diff = {diff, " cell_valid"};
          if (out_res.cell_column !== want.cell_column) diff = {diff, " cell_column"};
          if (out_res.cell_row !== want.cell_row) diff = {diff, " cell_row"};
          if (out_res.cell_char !== want.cell_char) diff = {diff, " cell_char"};
          if (out_res.cell_attr !== want.cell_attr) diff = {diff, " cell_attr"};
          if (out_res.fg_rgb !== want.fg_rgb) diff = {diff, " fg_rgb"};
          if (out_res.bg_rgb !== want.bg_rgb) diff = {diff, " bg_rgb"};
          if (out_res.scrolled !== want.scrolled) diff = {diff, " scrolled"};
          if (out_res.cursor_column !== want.cursor_column) diff = {diff, " cursor_column"};
          if (out_res.cursor_row !== want.cursor_row) diff = {diff, " cursor_row"};
          if (diff != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch in%s: expected %h, got %h", diff, want, out_res);
          end
        end
      end
      if (start && !busy) begin
        want = console_step(in_req);
        due_results.push_back(want);
        scroll_count += want.scrolled;
        if (in_req.cmd == CMD_CLEAR) clear_count++;
        if (in_req.cmd == CMD_READ) read_count++;
      end
      req_taken <= start && !busy;
    end else begin
      req_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] hue;
    color_reg = COLOR_RESET;
    blank_all();
    cur_x = 0;
    cur_y = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset color; the first ones are presented during the clearing pass and wait for it.
    post(CMD_READ, 8'h00, 6'd0, 6'd0);
    post(CMD_READ, 8'hFF, 6'(COLS - 1), 6'(ROWS - 1));
    post(CMD_READ, 8'h00, 6'(COLS), 6'd0);
    post(CMD_READ, 8'h00, 6'd0, 6'(ROWS));
    post(CMD_READ, 8'h00, 6'h3F, 6'h3F);
    post(CMD_PUT, CH_BACKSPACE, 6'd0, 6'd0);
    post(CMD_PUT, 8'h00, 6'h3F, 6'h3F);
    post(CMD_PUT, 8'hFF, 6'd0, 6'd0);
    post(CMD_PUT, 8'h41, 6'd0, 6'd0);
    post(CMD_PUT, CH_BACKSPACE, 6'd0, 6'd0);
    post(CMD_PUT, CH_NEWLINE, 6'd0, 6'd0);
    // A stored byte in the last cell wraps and scrolls the screen.
    post(CMD_SET, 8'h00, 6'(COLS - 1), 6'(ROWS - 1));
    post(CMD_PUT, 8'h5A, 6'd0, 6'd0);
    post(CMD_READ, 8'h00, 6'(COLS - 1), 6'(ROWS - 2));
    post(CMD_SET, 8'h00, 6'h3F, 6'd5);
    post(CMD_SET, 8'h00, 6'd3, 6'h3F);
    post(CMD_SET, 8'h00, 6'h3F, 6'h3F);
    post(CMD_SET, 8'h00, 6'd0, 6'(ROWS - 1));
    post(CMD_PUT, CH_NEWLINE, 6'd0, 6'd0);
    post(CMD_READ, 8'h00, 6'(COLS - 1), 6'(ROWS - 3));
    post(CMD_CLEAR, 8'hFF, 6'h3F, 6'h3F);
    post(CMD_READ, 8'h00, 6'd0, 6'd0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: hue = 8'h00;
        1: hue = 8'hFF;
        2: hue = 8'h0F;
        3: hue = 8'hF0;
        default: hue = 8'($urandom);
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= hue;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      color_reg = hue;
      color_count++;
      idle_on = p % 2;
      @(posedge clk);
      repeat (PHASE_ITEMS) post_random();
      settle();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests over %0d text colors, including %0d reads and %0d clears.",
             queued_total, color_count, read_count, clear_count);
    $display("Checked %0d results, %0d of them scrolls; %0d mismatches.",
             results_seen, scroll_count, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
